@@ hw/rtl/kabf_pkg.sv @@
package kabf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_FRAC       = 16;
  localparam int DIV_STEPS     = 16;   // two quotient bits per step

  typedef enum logic [1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_BIAS  = 2'd1,
    REG_R_MEAS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_DIV0,
    ST_DIV0W,
    ST_DIV1W,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_C5,
    ST_C6,
    ST_C7,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [32:0] b;
    logic               frac;   // 1: shift by frac bits, 0: shift by dt fraction
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic [31:0]        den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if ((&v[34:31]) || !(|v[34:31])) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(35'(a) + 35'(b));
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(35'(a) - 35'(b));
  endfunction

endpackage

@@ hw/rtl/kabf_mul.sv @@
module kabf_mul #(
  parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  kabf_pkg::mul_req_t req,
  output logic signed [31:0] res
);
  import kabf_pkg::*;

  logic signed [64:0] prod;
  logic signed [64:0] prod_r;
  logic               frac_r;
  logic signed [64:0] shifted;

  assign prod = 65'(req.a) * 65'(req.b);

  always_ff @(posedge clk) begin
    prod_r <= prod;
    frac_r <= req.frac;
  end

  // arithmetic shift gives floor rounding
  always_comb begin
    shifted = frac_r ? (prod_r >>> FRAC_BITS) : (prod_r >>> DT_FRAC);
    if ((&shifted[64:31]) || !(|shifted[64:31])) begin
      res = shifted[31:0];
    end else if (shifted[64]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7fff_ffff;
    end
  end

endmodule

@@ hw/rtl/kabf_div.sv @@
module kabf_div #(
  parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kabf_pkg::div_req_t req,
  output logic               done,
  output logic signed [31:0] quot
);
  import kabf_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r;
  logic [31:0]   quo_r;
  logic [31:0]   den_r;
  logic          neg_r;
  logic          ovf_r;

  logic [31:0] mag;
  logic [63:0] wide;
  logic [32:0] r1;
  logic [32:0] r2;
  logic [31:0] rem1;
  logic [31:0] rem2;
  logic        b1;
  logic        b2;

  always_comb begin
    mag  = req.num[31] ? (~req.num + 32'd1) : req.num;
    wide = {32'd0, mag} << FRAC_BITS;
  end

  // two restoring steps per cycle
  always_comb begin
    r1   = {rem_r, quo_r[31]};
    b1   = r1 >= {1'b0, den_r};
    rem1 = b1 ? 32'(r1 - {1'b0, den_r}) : r1[31:0];
    r2   = {rem1, quo_r[30]};
    b2   = r2 >= {1'b0, den_r};
    rem2 = b2 ? 32'(r2 - {1'b0, den_r}) : r2[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= wide[63:32];
      quo_r <= wide[31:0];
      den_r <= req.den;
      neg_r <= req.num[31];
      ovf_r <= wide[63:32] >= req.den;
    end else if (busy_r) begin
      rem_r <= rem2;
      quo_r <= {quo_r[29:0], b1, b2};
    end
  end

  assign done = done_r;

  // truncate toward zero, saturate to 32 bits
  always_comb begin
    if (ovf_r) begin
      quot = neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (neg_r) begin
      quot = (quo_r > 32'h8000_0000) ? 32'sh8000_0000 : (~quo_r + 32'd1);
    end else begin
      quot = quo_r[31] ? 32'sh7fff_ffff : quo_r;
    end
  end

endmodule

@@ hw/rtl/kalman_angle_bias_filter.sv @@
// two-state kalman filter: tilt angle and gyro bias, signed fixed point
//
// input channel: in_valid / in_stall with measured angle, gyro rate and the
// time step since the last sample; a transfer happens when in_valid is high
// and in_stall is low. in_stall is high while an item is being worked on.
// result channel: out_valid / out_stall with the filtered angle and the bias
// estimate; out_valid holds with stable data until a transfer.
// config port: cfg_we writes cfg_wdata into the register at cfg_index
// (0 angle process noise, 1 bias process noise, 2 measurement noise);
// other indexes are ignored. write only while the block is idle.
// one item is worked on at a time. the time per item is set by two radix-4
// divisions for the gains, skipped when the innovation variance is not
// positive, and by 10 passes through the one shared 32x33 multiplier.
// reset (rst_n low, synchronous): estimates and covariance go to zero, noise
// registers to their defaults, both channels idle.
// a stalled result waits in the output register; the next input can still
// be taken, and its result waits in the done state until the register frees.
module kalman_angle_bias_filter #(
  parameter int FRAC_BITS = kabf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [24:0] in_measured_angle,
  input  logic signed [25:0] in_measured_rate,
  input  logic [15:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_filtered_angle,
  output logic signed [31:0] out_estimated_bias,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);
  import kabf_pkg::*;

  state_t state_r, state_nxt;

  // noise registers
  logic [15:0] qa_r;
  logic [15:0] qb_r;
  logic [30:0] rm_r;

  // filter state
  logic signed [31:0] angle_r, angle_nxt;
  logic signed [31:0] bias_r, bias_nxt;
  logic signed [31:0] paa_r, paa_nxt;
  logic signed [31:0] pab_r, pab_nxt;
  logic signed [31:0] pba_r, pba_nxt;
  logic signed [31:0] pbb_r, pbb_nxt;

  // per-item working registers
  logic signed [31:0] z_r, z_nxt;
  logic signed [31:0] w_r, w_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic signed [31:0] tmp_r, tmp_nxt;   // rate, then t
  logic signed [31:0] dp_r, dp_nxt;     // pbb * dt
  logic [31:0]        s_r, s_nxt;       // innovation variance
  logic signed [31:0] k0_r, k0_nxt;
  logic signed [31:0] k1_r, k1_nxt;
  logic signed [31:0] y_r, y_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_angle_r, out_angle_nxt;
  logic signed [31:0] out_bias_r, out_bias_nxt;

  mul_req_t           mreq;
  logic signed [31:0] mres;
  div_req_t           dreq;
  logic               ddone;
  logic signed [31:0] dquot;

  logic               in_xfer;
  logic signed [32:0] s_full;
  logic signed [32:0] dt_op;

  kabf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .req (mreq),
    .res (mres)
  );

  kabf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (ddone),
    .quot  (dquot)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign dt_op    = $signed({17'd0, dt_r});
  assign s_full   = 33'(paa_r) + $signed({2'b00, rm_r});

  always_comb begin
    state_nxt     = state_r;
    angle_nxt     = angle_r;
    bias_nxt      = bias_r;
    paa_nxt       = paa_r;
    pab_nxt       = pab_r;
    pba_nxt       = pba_r;
    pbb_nxt       = pbb_r;
    z_nxt         = z_r;
    w_nxt         = w_r;
    dt_nxt        = dt_r;
    tmp_nxt       = tmp_r;
    dp_nxt        = dp_r;
    s_nxt         = s_r;
    k0_nxt        = k0_r;
    k1_nxt        = k1_r;
    y_nxt         = y_r;
    out_angle_nxt = out_angle_r;
    out_bias_nxt  = out_bias_r;
    out_valid_nxt = out_valid_r && out_stall;
    mreq          = '0;
    dreq          = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          z_nxt     = 32'(in_measured_angle);
          w_nxt     = 32'(in_measured_rate);
          dt_nxt    = in_time_step;
          state_nxt = ST_RATE;
        end
      end
      ST_RATE: begin
        tmp_nxt   = sub_sat(w_r, bias_r);
        state_nxt = ST_M1;
      end
      ST_M1: begin
        // rate * dt
        mreq.a    = tmp_r;
        mreq.b    = dt_op;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        angle_nxt = add_sat(angle_r, mres);
        mreq.a    = pbb_r;
        mreq.b    = dt_op;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        // one saturation over the whole sum
        dp_nxt    = mres;
        tmp_nxt   = sat32(35'(mres) - 35'(pab_r) - 35'(pba_r)
                          + $signed({19'd0, qa_r}));
        state_nxt = ST_M4;
      end
      ST_M4: begin
        mreq.a    = tmp_r;
        mreq.b    = dt_op;
        state_nxt = ST_M5;
      end
      ST_M5: begin
        paa_nxt   = add_sat(paa_r, mres);
        pab_nxt   = sub_sat(pab_r, dp_r);
        pba_nxt   = sub_sat(pba_r, dp_r);
        mreq.a    = $signed({16'd0, qb_r});
        mreq.b    = dt_op;
        state_nxt = ST_M6;
      end
      ST_M6: begin
        pbb_nxt   = add_sat(pbb_r, mres);
        y_nxt     = sub_sat(z_r, angle_r);
        state_nxt = ST_DIV0;
      end
      ST_DIV0: begin
        // nonpositive innovation variance: zero gains
        if (s_full[32] || (s_full == '0)) begin
          k0_nxt    = '0;
          k1_nxt    = '0;
          state_nxt = ST_C1;
        end else begin
          s_nxt      = s_full[31:0];
          dreq.start = 1'b1;
          dreq.num   = paa_r;
          dreq.den   = s_full[31:0];
          state_nxt  = ST_DIV0W;
        end
      end
      ST_DIV0W: begin
        if (ddone) begin
          k0_nxt     = dquot;
          dreq.start = 1'b1;
          dreq.num   = pba_r;
          dreq.den   = s_r;
          state_nxt  = ST_DIV1W;
        end
      end
      ST_DIV1W: begin
        if (ddone) begin
          k1_nxt    = dquot;
          state_nxt = ST_C1;
        end
      end
      ST_C1: begin
        mreq.a    = k0_r;
        mreq.b    = 33'(y_r);
        mreq.frac = 1'b1;
        state_nxt = ST_C2;
      end
      ST_C2: begin
        angle_nxt = add_sat(angle_r, mres);
        mreq.a    = k1_r;
        mreq.b    = 33'(y_r);
        mreq.frac = 1'b1;
        state_nxt = ST_C3;
      end
      ST_C3: begin
        bias_nxt  = add_sat(bias_r, mres);
        mreq.a    = k1_r;
        mreq.b    = 33'(paa_r);
        mreq.frac = 1'b1;
        state_nxt = ST_C4;
      end
      ST_C4: begin
        // pba uses the old paa, so it goes before paa
        pba_nxt   = sub_sat(pba_r, mres);
        mreq.a    = k0_r;
        mreq.b    = 33'(paa_r);
        mreq.frac = 1'b1;
        state_nxt = ST_C5;
      end
      ST_C5: begin
        paa_nxt   = sub_sat(paa_r, mres);
        mreq.a    = k1_r;
        mreq.b    = 33'(pab_r);
        mreq.frac = 1'b1;
        state_nxt = ST_C6;
      end
      ST_C6: begin
        // pbb uses the old pab, so it goes before pab
        pbb_nxt   = sub_sat(pbb_r, mres);
        mreq.a    = k0_r;
        mreq.b    = 33'(pab_r);
        mreq.frac = 1'b1;
        state_nxt = ST_C7;
      end
      ST_C7: begin
        pab_nxt   = sub_sat(pab_r, mres);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free
        if (!out_valid_r || !out_stall) begin
          out_angle_nxt = angle_r;
          out_bias_nxt  = bias_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      angle_r     <= '0;
      bias_r      <= '0;
      paa_r       <= '0;
      pab_r       <= '0;
      pba_r       <= '0;
      pbb_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      angle_r     <= angle_nxt;
      bias_r      <= bias_nxt;
      paa_r       <= paa_nxt;
      pab_r       <= pab_nxt;
      pba_r       <= pba_nxt;
      pbb_r       <= pbb_nxt;
    end
  end

  // config registers, defaults 0.001, 0.003 and 0.03 in q16.16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= 16'd66;
      qb_r <= 16'd197;
      rm_r <= 31'd1966;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_Q_ANGLE: qa_r <= cfg_wdata[15:0];
        REG_Q_BIAS:  qb_r <= cfg_wdata[15:0];
        REG_R_MEAS:  rm_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    z_r         <= z_nxt;
    w_r         <= w_nxt;
    dt_r        <= dt_nxt;
    tmp_r       <= tmp_nxt;
    dp_r        <= dp_nxt;
    s_r         <= s_nxt;
    k0_r        <= k0_nxt;
    k1_r        <= k1_nxt;
    y_r         <= y_nxt;
    out_angle_r <= out_angle_nxt;
    out_bias_r  <= out_bias_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_angle_r;
  assign out_estimated_bias = out_bias_r;

endmodule
